@@ rtl/core/lst_pkg.sv @@
package lst_pkg;

    // Internal index width, sized for up to 64 points per swing
    localparam int IW = 6;
    // Divider dividend width and square-root operand widths
    localparam int DW = 22;
    localparam int SW = 28;
    localparam int RW = 14;
    localparam int HW = 15 + RW;

    // Configuration register indexes
    localparam logic CFG_SWING_HEIGHT = 1'b0;
    localparam logic CFG_POINTS       = 1'b1;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] end_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [4:0]         point_index;
        logic               last_point;
    } t_out_item;

    // One swing, classified and ready for the point sequencer
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] base;
        logic [15:0]        mag_x;
        logic [15:0]        mag_y;
        logic               neg_x;
        logic               neg_y;
        logic [IW-1:0]      m;
        logic [14:0]        h;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_HQ,
        S_DIV_START,
        S_DIV,
        S_OUT
    } t_back_state;

endpackage

@@ rtl/core/lst_front.sv @@
module lst_front
    import lst_pkg::*;
#(
    parameter int MAX_POINTS = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_in_item      i_item,
    input  logic [14:0]   i_swing_height,
    input  logic [4:0]    i_points,
    output logic          o_job_valid,
    output t_job          o_job,
    input  logic          i_job_pop
);

    logic [IW:0]          w_n_ext;
    logic [IW:0]          w_n;
    logic signed [16:0]   w_dx;
    logic signed [16:0]   w_dy;
    logic signed [16:0]   w_ax;
    logic signed [16:0]   w_ay;
    t_job                 w_job;
    t_job                 r_q [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic                 w_push;

    // Clamp the point count and classify the move
    always_comb begin
        w_n_ext = {{(IW - 4){1'b0}}, i_points};
        if (w_n_ext < (IW + 1)'(4)) begin
            w_n = (IW + 1)'(4);
        end else if (w_n_ext > (IW + 1)'(MAX_POINTS)) begin
            w_n = (IW + 1)'(MAX_POINTS);
        end else begin
            w_n = w_n_ext;
        end
        w_dx = {i_item.end_x[15], i_item.end_x} - {i_item.start_x[15], i_item.start_x};
        w_dy = {i_item.end_y[15], i_item.end_y} - {i_item.start_y[15], i_item.start_y};
        w_ax = w_dx[16] ? -w_dx : w_dx;
        w_ay = w_dy[16] ? -w_dy : w_dy;
        w_job.sx    = i_item.start_x;
        w_job.sy    = i_item.start_y;
        w_job.base  = (i_item.start_z > i_item.end_z) ? i_item.start_z : i_item.end_z;
        w_job.mag_x = w_ax[15:0];
        w_job.mag_y = w_ay[15:0];
        w_job.neg_x = w_dx[16];
        w_job.neg_y = w_dy[16];
        w_job.m     = IW'(w_n - (IW + 1)'(1));
        w_job.h     = i_swing_height;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // Two-entry queue toward the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_job_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

@@ rtl/core/lst_div.sv @@
module lst_div
    import lst_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [IW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [IW-1:0] r_rem;
    logic [DW-1:0] r_num;
    logic [IW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic [IW:0]   w_trial;
    logic          w_ge;

    // One restoring step per cycle
    assign w_trial = {r_rem, r_num[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign o_busy  = (r_cnt != '0);
    assign o_quot  = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_dividend;
            r_div <= i_divisor;
        end else if (o_busy) begin
            r_rem <= w_ge ? IW'(w_trial - {1'b0, r_div}) : w_trial[IW-1:0];
            r_num <= {r_num[DW-2:0], w_ge};
        end
    end

endmodule

@@ rtl/core/lst_back.sv @@
module lst_back
    import lst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_item
);

    localparam int SCW = $clog2(SW / 2 + 1);

    t_back_state          r_state;
    t_back_state          n_state;
    t_job                 r_job;
    logic [IW-1:0]        r_i;
    logic [2*IW-1:0]      r_prod;
    logic [DW-1:0]        r_px;
    logic [DW-1:0]        r_py;
    logic [SW-1:0]        r_val;
    logic [RW:0]          r_rem;
    logic [RW-1:0]        r_root;
    logic [SCW-1:0]       r_scnt;
    logic [HW-1:0]        r_hq;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 w_div_start;
    logic                 w_busy_z;
    logic                 w_busy_x;
    logic                 w_busy_y;
    logic [DW-1:0]        w_qz;
    logic [DW-1:0]        w_qx;
    logic [DW-1:0]        w_qy;
    logic [RW+2:0]        w_srem;
    logic [RW+2:0]        w_strial;
    logic                 w_sge;
    logic                 w_out_free;
    logic                 w_last;
    logic signed [17:0]   w_x;
    logic signed [17:0]   w_y;
    logic signed [17:0]   w_z;
    t_out_item            w_out;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_last     = (r_i == r_job.m);
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

    // One square-root digit per cycle
    assign w_srem   = {r_rem, r_val[SW-1:SW-2]};
    assign w_strial = {1'b0, r_root, 2'b01};
    assign w_sge    = (w_srem >= w_strial);

    // Divide lift, x and y by m in parallel
    lst_div u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_hq[HW-1:HW-DW]),
        .i_divisor  (r_job.m),
        .o_busy     (w_busy_z),
        .o_quot     (w_qz)
    );

    lst_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_px),
        .i_divisor  (r_job.m),
        .o_busy     (w_busy_x),
        .o_quot     (w_qx)
    );

    lst_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_py),
        .i_divisor  (r_job.m),
        .o_busy     (w_busy_y),
        .o_quot     (w_qy)
    );

    // Assemble the point from the quotients
    always_comb begin
        w_x = {{2{r_job.sx[15]}}, r_job.sx}
            + (r_job.neg_x ? -{2'b00, w_qx[15:0]} : {2'b00, w_qx[15:0]});
        w_y = {{2{r_job.sy[15]}}, r_job.sy}
            + (r_job.neg_y ? -{2'b00, w_qy[15:0]} : {2'b00, w_qy[15:0]});
        w_z = {{2{r_job.base[15]}}, r_job.base} - {2'b00, w_qz[15:0]};
        w_out.point_x     = w_x[15:0];
        w_out.point_y     = w_y[15:0];
        w_out.point_z     = (w_z < -18'sd32768) ? 16'sh8000 : w_z[15:0];
        w_out.point_index = r_i[4:0];
        w_out.last_point  = w_last;
    end

    // Sequence the points of one swing
    always_comb begin
        n_state     = r_state;
        o_job_pop   = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_scnt == SCW'(1)) begin
                    n_state = S_HQ;
                end
            end
            S_HQ: begin
                n_state = S_DIV_START;
            end
            S_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (!w_busy_z && !w_busy_x && !w_busy_y) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = w_last ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the output item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_i   <= '0;
            end
            S_MUL: begin
                r_prod <= (2 * IW)'(r_i) * (2 * IW)'(r_job.m - r_i);
                r_px   <= DW'(r_job.mag_x) * DW'(r_i);
                r_py   <= DW'(r_job.mag_y) * DW'(r_i);
                r_val  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_scnt <= SCW'(SW / 2 + 1);
            end
            S_SQRT: begin
                // Load the operand, then take one digit per cycle
                if (r_scnt == SCW'(SW / 2 + 1)) begin
                    r_val <= {r_prod, {(SW - 2 * IW){1'b0}}};
                end else begin
                    r_val <= {r_val[SW-3:0], 2'b00};
                end
                if (r_scnt != SCW'(SW / 2 + 1)) begin
                    r_rem  <= w_sge ? (RW + 1)'(w_srem - w_strial) : w_srem[RW:0];
                    r_root <= {r_root[RW-2:0], w_sge};
                end
                if (r_scnt != SCW'(1)) begin
                    r_scnt <= r_scnt - SCW'(1);
                end
            end
            S_HQ: begin
                r_hq <= HW'(r_job.h) * HW'(r_root);
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out <= w_out;
                    r_i   <= r_i + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/core/leg_swing_trajectory_generator_top.sv @@
// Leg swing trajectory generator.
// Input channel (i_valid/o_ready, i_item) takes a start and an end point; each
// item yields a swing of points_per_step points on the output channel
// (o_valid/i_ready, o_item), with point_index counting from zero and
// last_point set on the final point of the swing.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 swing height, 1 points_per_step) at once; write only while idle.
// The front stage clamps the point count, forms the deltas and the base
// height and parks up to two swings in a queue, so new items are taken
// while a swing is still being emitted.
// Each point passes in order through a multiply, the digit-serial square
// root (operand load and 14 digits), a height multiply, a divider start and
// the three parallel divide-by-(n-1) units, then into the output register.
// The sequencer computes the points of a swing one after another and
// starts the next point only once the output register has taken the last.
// Reset clears the queue, the sequencer and the output valid, sets the
// swing height to 0 and points_per_step to 4. When the receiver stalls the
// output register holds its item and the sequencer waits in front of it.
module leg_swing_trajectory_generator_top
    import lst_pkg::*;
#(
    parameter int MAX_POINTS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    logic [14:0] r_swing_height;
    logic [4:0]  r_points;
    logic        w_job_valid;
    logic        w_job_pop;
    t_job        w_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swing_height <= 15'd0;
            r_points       <= 5'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SWING_HEIGHT: r_swing_height <= i_cfg_data;
                CFG_POINTS:       r_points       <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    lst_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_item         (i_item),
        .i_swing_height (r_swing_height),
        .i_points       (r_points),
        .o_job_valid    (w_job_valid),
        .o_job          (w_job),
        .i_job_pop      (w_job_pop)
    );

    lst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule
